### hw/rtl/breakpoint_watchpoint_unit_assert.svh
// Assertion macros for the breakpoint/watchpoint unit
`ifndef BREAKPOINT_WATCHPOINT_UNIT_ASSERT_SVH
`define BREAKPOINT_WATCHPOINT_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BWU_ASSERT_IMP(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the condition
`define BWU_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`endif

### hw/rtl/bwu_pkg.sv
`default_nettype none
package bwu_pkg;
  localparam int BREAK_SLOTS_DEF = 64;
  localparam int WATCH_SLOTS_DEF = 32;
  localparam int MAX_WATCH_LEN_DEF = 256;
  localparam int WLEN_W = 12;

  typedef enum logic [3:0] {
    CMD_ATTACH   = 4'd0,
    CMD_DETACH   = 4'd1,
    CMD_BREAK    = 4'd2,
    CMD_CONTINUE = 4'd3,
    CMD_STEP     = 4'd4,
    CMD_INSERT   = 4'd5,
    CMD_REMOVE   = 4'd6,
    CMD_INSTR    = 4'd7,
    CMD_ACCESS   = 4'd8,
    CMD_QUERY    = 4'd9,
    CMD_NONE     = 4'd10
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADLEN  = 2'd2;
  localparam logic [1:0] ST_BADTYPE = 2'd3;

  // One classified item as it travels from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] address;
    logic [11:0] length;
    logic        is_brk;     // breakpoint table target
    logic [1:0]  kind;       // watch kind 1 write, 2 read, 3 access
    logic [1:0]  pre_status; // bad length or bad type decided up front
    logic        write_op;
  } item_t;

  function automatic cmd_t decode_cmd(input logic [3:0] c);
    cmd_t r;
    r = CMD_NONE;
    unique case (c)
      4'd0: r = CMD_ATTACH;
      4'd1: r = CMD_DETACH;
      4'd2: r = CMD_BREAK;
      4'd3: r = CMD_CONTINUE;
      4'd4: r = CMD_STEP;
      4'd5: r = CMD_INSERT;
      4'd6: r = CMD_REMOVE;
      4'd7: r = CMD_INSTR;
      4'd8: r = CMD_ACCESS;
      4'd9: r = CMD_QUERY;
      default: r = CMD_NONE;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/breakpoint_watchpoint_unit.sv
// Each item passes the back-end states scan and done; a removal that finds its entry
// also passes move-read and move-write to copy the last entry into the freed slot.
// The one-port scan walks the table the item touches (break table for instructions,
// watch table for accesses). The back end takes a new item only once the last result
// is registered, which waits while the result slot is still full.
// Reset (rst, synchronous) empties both tables and the queues and clears all flags.
`default_nettype none
module breakpoint_watchpoint_unit import bwu_pkg::*; #(
  parameter int BREAK_SLOTS   = BREAK_SLOTS_DEF,
  parameter int WATCH_SLOTS   = WATCH_SLOTS_DEF,
  parameter int MAX_WATCH_LEN = MAX_WATCH_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [3:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [11:0] length,
  input  wire logic [3:0]  point_type,
  input  wire logic        write_op,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [1:0]  status,
  output      logic        stop,
  output      logic [1:0]  stop_kind,
  output      logic [31:0] stop_address
);
  logic  q_valid, q_take;
  item_t q_item;

  bwu_front #(.MAX_WATCH_LEN(MAX_WATCH_LEN)) u_front (
    .clk, .rst, .push, .full, .command, .address, .length, .point_type,
    .write_op, .q_valid, .q_item, .q_take
  );

  bwu_back #(.BREAK_SLOTS(BREAK_SLOTS), .WATCH_SLOTS(WATCH_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_take, .empty, .pop,
    .status, .stop, .stop_kind, .stop_address
  );
endmodule
`default_nettype wire

### hw/rtl/bwu_ram.sv
`default_nettype none
module bwu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/bwu_front.sv
`default_nettype none
module bwu_front import bwu_pkg::*; #(
  parameter int MAX_WATCH_LEN = MAX_WATCH_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [3:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [11:0] length,
  input  wire logic [3:0]  point_type,
  input  wire logic        write_op,
  output      logic        q_valid,
  output      item_t       q_item,
  input  wire logic        q_take
);
  // Two-entry queue between front and back
  item_t       slot [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  item_t       cls;
  logic        do_push, do_pop;

  always_comb begin
    cls = '0;
    cls.cmd      = decode_cmd(command);
    cls.address  = address;
    cls.length   = length;
    cls.write_op = write_op;
    cls.is_brk   = (point_type <= 4'd1);
    cls.kind     = 2'(point_type - 4'd1);
    if (point_type > 4'd4) begin
      cls.pre_status = ST_BADTYPE;
    end else if (!cls.is_brk &&
                 (length == '0 || length > WLEN_W'(MAX_WATCH_LEN))) begin
      cls.pre_status = ST_BADLEN;
    end else begin
      cls.pre_status = ST_OK;
    end
  end

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/bwu_back.sv
`default_nettype none
module bwu_back import bwu_pkg::*; #(
  parameter int BREAK_SLOTS = BREAK_SLOTS_DEF,
  parameter int WATCH_SLOTS = WATCH_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output      logic        q_take,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [1:0]  status,
  output      logic        stop,
  output      logic [1:0]  stop_kind,
  output      logic [31:0] stop_address
);
  localparam int BA_W = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int WA_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam int BC_W = $clog2(BREAK_SLOTS + 1);
  localparam int WC_W = $clog2(WATCH_SLOTS + 1);
  localparam int WE_W = 32 + WLEN_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MOVE_RD, S_MOVE_WR, S_DONE
  } state_t;

  state_t          state;
  item_t           cur;
  logic [BC_W-1:0] break_used;
  logic [WC_W-1:0] watch_used;
  logic            attached, halt_pending, step_armed;
  logic [1:0]      hit_kind;
  logic [31:0]     hit_address;
  logic [8:0]      idx;      // scan index, wide enough for 256
  logic [8:0]      lat;      // index of the entry whose read data is due
  logic            rd_live;  // read data valid this cycle
  logic            found;
  logic [8:0]      found_idx;
  logic [1:0]      found_kind;
  logic            res_valid;

  // Break table memory
  logic            b_we;
  logic [BA_W-1:0] b_waddr, b_raddr;
  logic [31:0]     b_wdata, b_rdata;
  // Watch table memory: address, length, kind
  logic            w_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [WE_W-1:0] w_wdata, w_rdata;

  bwu_ram #(.WIDTH(32), .DEPTH(BREAK_SLOTS)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  bwu_ram #(.WIDTH(WE_W), .DEPTH(WATCH_SLOTS)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  logic [31:0]       wa;
  logic [WLEN_W-1:0] wl;
  logic [1:0]        wk;
  logic [31:0]       acc_end, w_end;
  logic              b_match, w_match, acc_hit, rd_match;
  logic [8:0]        used_n;
  logic              use_brk;
  logic              tbl_full;
  logic              fire;
  logic [1:0]        res_status;
  logic              res_stop;
  logic [1:0]        res_kind;
  logic [31:0]       res_addr;

  assign wa = w_rdata[WE_W-1 -: 32];
  assign wl = w_rdata[2 +: WLEN_W];
  assign wk = w_rdata[1:0];
  assign acc_end = cur.address + 32'(cur.length);
  assign w_end   = wa + 32'(wl);
  assign b_match = (b_rdata == cur.address);
  assign w_match = (wa == cur.address) && (wl == cur.length) && (wk == cur.kind);
  assign acc_hit = !(acc_end <= wa || cur.address >= w_end) &&
                   (cur.write_op ? (wk == 2'd1 || wk == 2'd3)
                                 : (wk == 2'd2 || wk == 2'd3));
  // Table touched by this item: instructions scan breaks, accesses watches
  assign use_brk = (cur.cmd == CMD_INSTR) || cur.is_brk && cur.cmd != CMD_ACCESS;
  assign used_n  = use_brk ? 9'(break_used) : 9'(watch_used);
  assign rd_match = (cur.cmd == CMD_ACCESS) ? acc_hit : (use_brk ? b_match : w_match);
  assign tbl_full = use_brk ? (break_used >= BC_W'(BREAK_SLOTS))
                            : (watch_used >= WC_W'(WATCH_SLOTS));

  // Result fields of the current item, registered when the transfer slot is free
  assign fire = (state == S_DONE) && (!res_valid || pop);
  assign res_status = (cur.cmd == CMD_INSERT && cur.pre_status == ST_OK && !found &&
                       tbl_full) ? ST_FULL :
                      (cur.cmd == CMD_INSERT || cur.cmd == CMD_REMOVE) ? cur.pre_status :
                      ST_OK;
  assign res_stop = (cur.cmd == CMD_INSTR) && (attached || break_used != '0) &&
                    (halt_pending || step_armed || found);
  assign res_kind = (cur.cmd == CMD_QUERY) ? hit_kind : 2'd0;
  assign res_addr = (cur.cmd == CMD_ACCESS && found) ? cur.address : hit_address;

  assign empty  = !res_valid;
  assign q_take = (state == S_IDLE) && q_valid;

  always_comb begin
    b_we = 1'b0; w_we = 1'b0;
    b_waddr = BA_W'(idx); w_waddr = WA_W'(idx);
    b_wdata = cur.address;
    w_wdata = {cur.address, cur.length, cur.kind};
    b_raddr = BA_W'(idx); w_raddr = WA_W'(idx);
    if (state == S_MOVE_RD) begin
      b_raddr = BA_W'(used_n - 9'd1);
      w_raddr = WA_W'(used_n - 9'd1);
    end
    if (state == S_MOVE_WR) begin
      b_waddr = BA_W'(found_idx); w_waddr = WA_W'(found_idx);
      b_wdata = b_rdata; w_wdata = w_rdata;
      b_we = use_brk; w_we = !use_brk;
    end else if (state == S_DONE && cur.cmd == CMD_INSERT && !found &&
                 cur.pre_status == ST_OK) begin
      b_waddr = BA_W'(break_used); w_waddr = WA_W'(watch_used);
      b_we = use_brk && (break_used < BC_W'(BREAK_SLOTS));
      w_we = !use_brk && (watch_used < WC_W'(WATCH_SLOTS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      break_used <= '0; watch_used <= '0;
      attached <= 1'b0; halt_pending <= 1'b0; step_armed <= 1'b0;
      hit_kind <= '0; hit_address <= '0;
      res_valid <= 1'b0;
      idx <= '0; lat <= '0; rd_live <= 1'b0; found <= 1'b0; found_idx <= '0;
      found_kind <= '0;
      cur <= '0;
      status <= '0; stop <= 1'b0; stop_kind <= '0; stop_address <= '0;
    end else begin
      if (fire) res_valid <= 1'b1;
      else if (pop && res_valid) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            idx <= '0; rd_live <= 1'b0; found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read data is registered, so it belongs to the index issued in the cycle before
          if (rd_live && !found && rd_match) begin
            found <= 1'b1;
            found_idx <= lat;
            found_kind <= wk;
          end
          lat <= idx;
          if (!(cur.cmd == CMD_INSERT || cur.cmd == CMD_REMOVE ||
                cur.cmd == CMD_INSTR || cur.cmd == CMD_ACCESS) ||
              cur.pre_status != ST_OK && cur.cmd != CMD_INSTR &&
              cur.cmd != CMD_ACCESS ||
              (rd_live && !found && rd_match) ||
              (idx >= used_n && !rd_live) ||
              (idx >= used_n && rd_live)) begin
            rd_live <= 1'b0;
            if (rd_live && !found && rd_match) begin
              state <= (cur.cmd == CMD_REMOVE) ? S_MOVE_RD : S_DONE;
            end else if (idx >= used_n && rd_live) begin
              state <= S_DONE;
            end else if (idx >= used_n || !(cur.cmd == CMD_INSERT ||
                         cur.cmd == CMD_REMOVE || cur.cmd == CMD_INSTR ||
                         cur.cmd == CMD_ACCESS) || cur.pre_status != ST_OK) begin
              state <= S_DONE;
            end
          end else begin
            idx <= idx + 9'd1;
            rd_live <= 1'b1;
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          if (use_brk) break_used <= break_used - BC_W'(1);
          else watch_used <= watch_used - WC_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (fire) begin
            status <= res_status; stop <= res_stop; stop_kind <= res_kind;
            stop_address <= res_addr;
            unique case (cur.cmd)
              CMD_ATTACH: begin attached <= 1'b1; halt_pending <= 1'b1; end
              CMD_DETACH: begin
                attached <= 1'b0; halt_pending <= 1'b0; step_armed <= 1'b0;
                hit_kind <= '0; break_used <= '0; watch_used <= '0;
              end
              CMD_BREAK: halt_pending <= 1'b1;
              CMD_CONTINUE: step_armed <= 1'b0;
              CMD_STEP: step_armed <= 1'b1;
              CMD_INSERT: begin
                if (cur.pre_status == ST_OK && !found && !tbl_full) begin
                  if (use_brk) break_used <= break_used + BC_W'(1);
                  else watch_used <= watch_used + WC_W'(1);
                end
              end
              CMD_INSTR: begin
                if (attached || break_used != '0) begin
                  halt_pending <= 1'b0; step_armed <= 1'b0;
                end
              end
              CMD_ACCESS: begin
                if (found) begin
                  hit_kind <= found_kind;
                  hit_address <= cur.address;
                  halt_pending <= 1'b1;
                end
              end
              CMD_QUERY: hit_kind <= '0;
              default: ;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/bwu_checker.sv
`default_nettype none
`include "breakpoint_watchpoint_unit_assert.svh"
module bwu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status,
  input wire logic        stop,
  input wire logic [1:0]  stop_kind,
  input wire logic [31:0] stop_address
);
  `BWU_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty, "result dropped")
  `BWU_ASSERT_NEXT(a_stable, clk, rst, !empty && !pop, $stable({status, stop, stop_kind, stop_address}), "waiting result changed")
  `BWU_ASSERT_IMP(a_one_field, clk, rst, !empty && stop, status == 2'd0 && stop_kind == 2'd0, "stop with other fields")
  `BWU_ASSERT_IMP(a_kind_only, clk, rst, !empty && stop_kind != 2'd0, status == 2'd0, "query with status")
endmodule
bind breakpoint_watchpoint_unit bwu_checker u_chk (
  .clk, .rst, .empty, .pop, .status, .stop, .stop_kind, .stop_address
);
`default_nettype wire

### sim/tb_top.sv
module tb_top;
  import bwu_pkg::*;

  localparam int NBRK = BREAK_SLOTS_DEF;
  localparam int NWAT = WATCH_SLOTS_DEF;
  localparam int MAXLEN = MAX_WATCH_LEN_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  command = 4'd0;
  logic [31:0] address = 32'd0;
  logic [11:0] length = 12'd0;
  logic [3:0]  point_type = 4'd0;
  logic        write_op = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic        stop;
  logic [1:0]  stop_kind;
  logic [31:0] stop_address;

  typedef struct {
    logic [1:0]  status;
    logic        stop;
    logic [1:0]  stop_kind;
    logic [31:0] stop_address;
  } answer_t;

  answer_t answer_q[$];
  int errors = 0;
  bit pop_stall_mode = 1'b0;

  // predictor state
  logic [31:0] bp_addr[NBRK];
  int          bp_cnt;
  logic [31:0] wp_addr[NWAT];
  logic [11:0] wp_len[NWAT];
  logic [1:0]  wp_kind[NWAT];
  int          wp_cnt;
  bit          attached, halt_req, step_on;
  logic [1:0]  last_hit_kind;
  logic [31:0] last_hit_addr;

  breakpoint_watchpoint_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .address(address), .length(length), .point_type(point_type),
    .write_op(write_op), .empty(empty), .pop(pop), .status(status),
    .stop(stop), .stop_kind(stop_kind), .stop_address(stop_address)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int find_bp(logic [31:0] a);
    for (int i = 0; i < bp_cnt; i++) if (bp_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_wp(logic [31:0] a, logic [11:0] l, logic [1:0] k);
    for (int i = 0; i < wp_cnt; i++)
      if (wp_addr[i] == a && wp_len[i] == l && wp_kind[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [1:0] edit_points(bit ins, logic [31:0] a, logic [11:0] l,
                                             logic [3:0] t);
    int idx;
    logic [1:0] k;
    if (t <= 4'd1) begin
      idx = find_bp(a);
      if (ins) begin
        if (idx >= 0) return ST_OK;
        if (bp_cnt >= NBRK) return ST_FULL;
        bp_addr[bp_cnt] = a;
        bp_cnt++;
      end else if (idx >= 0) begin
        bp_cnt--;
        bp_addr[idx] = bp_addr[bp_cnt];
      end
      return ST_OK;
    end
    if (t <= 4'd4) begin
      k = 2'(t - 4'd1);
      if (l == 12'd0 || l > MAXLEN) return ST_BADLEN;
      idx = find_wp(a, l, k);
      if (ins) begin
        if (idx >= 0) return ST_OK;
        if (wp_cnt >= NWAT) return ST_FULL;
        wp_addr[wp_cnt] = a;
        wp_len[wp_cnt] = l;
        wp_kind[wp_cnt] = k;
        wp_cnt++;
      end else if (idx >= 0) begin
        wp_cnt--;
        wp_addr[idx] = wp_addr[wp_cnt];
        wp_len[idx] = wp_len[wp_cnt];
        wp_kind[idx] = wp_kind[wp_cnt];
      end
      return ST_OK;
    end
    return ST_BADTYPE;
  endfunction

  function automatic answer_t predict_debug(logic [3:0] c, logic [31:0] a, logic [11:0] l,
                                            logic [3:0] t, logic w);
    answer_t r;
    logic [31:0] aend, ws, we;
    r.status = ST_OK;
    r.stop = 1'b0;
    r.stop_kind = 2'd0;
    case (c)
      CMD_ATTACH: begin
        attached = 1; halt_req = 1;
      end
      CMD_DETACH: begin
        attached = 0; halt_req = 0; step_on = 0;
        last_hit_kind = 2'd0; bp_cnt = 0; wp_cnt = 0;
      end
      CMD_BREAK: halt_req = 1;
      CMD_CONTINUE: step_on = 0;
      CMD_STEP: step_on = 1;
      CMD_INSERT: r.status = edit_points(1, a, l, t);
      CMD_REMOVE: r.status = edit_points(0, a, l, t);
      CMD_INSTR: begin
        if (attached || bp_cnt != 0) begin
          if (halt_req) begin halt_req = 0; r.stop = 1; end
          if (step_on) begin step_on = 0; r.stop = 1; end
          if (find_bp(a) >= 0) r.stop = 1;
        end
      end
      CMD_ACCESS: begin
        aend = a + 32'(l);
        for (int i = 0; i < wp_cnt; i++) begin
          ws = wp_addr[i];
          we = ws + 32'(wp_len[i]);
          if (aend <= ws || a >= we) continue;
          if (w ? (wp_kind[i] == 2'd2) : (wp_kind[i] == 2'd1)) continue;
          last_hit_addr = a;
          last_hit_kind = wp_kind[i];
          halt_req = 1;
          break;
        end
      end
      CMD_QUERY: begin
        r.stop_kind = last_hit_kind;
        last_hit_kind = 2'd0;
      end
      default: ;
    endcase
    r.stop_address = last_hit_addr;
    return r;
  endfunction

  // burst/gap sender
  int burst_left = 0;

  task automatic send_item(logic [3:0] c, logic [31:0] a, logic [11:0] l,
                           logic [3:0] t, logic w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    command <= c; address <= a; length <= l; point_type <= t; write_op <= w;
    push <= 1'b1;
    answer_q.push_back(predict_debug(c, a, l, t, w));
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // idle the input, then hold until every expected result has come
  task automatic wait_drain();
    int guard;
    guard = 0;
    push <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // receiver: stall pattern changes over time
  int pop_phase = 0;
  always @(posedge clk) begin
    pop_phase <= pop_phase + 1;
    if (rst) pop <= 1'b0;
    else if (!pop_stall_mode) pop <= 1'b1;
    else pop <= ((pop_phase % 7) < 3) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && pop && !empty) begin
      if (answer_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (stop !== e.stop) begin
          $error("stop exp %0d got %0d", e.stop, stop); errors++;
        end
        if (stop_kind !== e.stop_kind) begin
          $error("stop_kind exp %0d got %0d", e.stop_kind, stop_kind); errors++;
        end
        if (stop_address !== e.stop_address) begin
          $error("stop_address exp %h got %h", e.stop_address, stop_address); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 63)) << 4;
      1: return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_control_cmds();
    send_item(CMD_INSTR, 32'h100, 12'd4, 4'd0, 0);
    send_item(CMD_ATTACH, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_INSTR, 32'h100, 12'd0, 4'd0, 0);
    send_item(CMD_INSTR, 32'h104, 12'd0, 4'd0, 0);
    send_item(CMD_STEP, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_INSTR, 32'h108, 12'd0, 4'd0, 0);
    send_item(CMD_STEP, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_CONTINUE, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_BREAK, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_INSTR, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 1);
    send_item(4'd15, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 1);
    send_item(4'd10, 32'h0, 12'd0, 4'd0, 0);
  endtask

  task automatic test_table_edits();
    send_item(CMD_INSERT, 32'h200, 12'd0, 4'd0, 0);
    send_item(CMD_INSERT, 32'h200, 12'd0, 4'd1, 0);
    send_item(CMD_INSTR, 32'h200, 12'd0, 4'd0, 0);
    send_item(CMD_INSERT, 32'h0, 12'd0, 4'd2, 0);
    send_item(CMD_INSERT, 32'h0, 12'd257, 4'd3, 0);
    send_item(CMD_INSERT, 32'h0, 12'd256, 4'd5, 0);
    send_item(CMD_INSERT, 32'hFFFF_FFF0, 12'd256, 4'd4, 0);
    send_item(CMD_ACCESS, 32'h0000_0008, 12'd4, 4'd0, 0);
    send_item(CMD_QUERY, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_QUERY, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_REMOVE, 32'h200, 12'd0, 4'd0, 0);
    send_item(CMD_REMOVE, 32'h999, 12'd0, 4'd0, 0);
    send_item(CMD_REMOVE, 32'h0, 12'd0, 4'd4, 0);
  endtask

  // fill both tables to capacity, then overflow
  task automatic test_table_full();
    for (int i = 0; i <= NBRK; i++) send_item(CMD_INSERT, 32'(i * 4), 12'd0, 4'd0, 0);
    for (int i = 0; i <= NWAT; i++)
      send_item(CMD_INSERT, 32'(i * 64), 12'd16, 4'(2 + i % 3), 0);
    for (int i = 0; i < 8; i++)
      send_item(CMD_ACCESS, 32'(i * 64 + 8), 12'd4, 4'd0, 1'(i));
    send_item(CMD_REMOVE, 32'h0, 12'd16, 4'd2, 0);
    send_item(CMD_REMOVE, 32'h4, 12'd0, 4'd0, 0);
    send_item(CMD_DETACH, 32'h0, 12'd0, 4'd0, 0);
    send_item(CMD_INSTR, 32'h0, 12'd0, 4'd0, 0);
  endtask

  task automatic test_random(int count);
    logic [3:0] c, t;
    logic [31:0] a;
    logic [11:0] l;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_drain();
        pop_stall_mode = ~pop_stall_mode;
      end
      a = rand_addr();
      t = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
      l = ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(1, 32));
      case ($urandom_range(0, 19))
        0: c = CMD_ATTACH;
        1: c = ($urandom_range(0, 5) == 0) ? CMD_DETACH : CMD_BREAK;
        2: c = CMD_BREAK;
        3: c = CMD_CONTINUE;
        4: c = CMD_STEP;
        5, 6, 7: c = CMD_INSERT;
        8, 9: c = CMD_REMOVE;
        10, 11, 12, 13: c = CMD_INSTR;
        14, 15, 16: c = CMD_ACCESS;
        17: c = CMD_QUERY;
        default: c = 4'($urandom_range(0, 15));
      endcase
      send_item(c, a, l, t, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    bp_cnt = 0; wp_cnt = 0; attached = 0; halt_req = 0; step_on = 0;
    last_hit_kind = 2'd0; last_hit_addr = 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_control_cmds();
    test_table_edits();
    pop_stall_mode = 1'b1;
    test_table_full();
    wait_drain();
    test_random(1815);
    wait_drain();
    repeat (200) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d expected results never arrived", answer_q.size());
      errors++;
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bwu_pkg.sv
hw/rtl/bwu_ram.sv
hw/rtl/bwu_front.sv
hw/rtl/bwu_back.sv
hw/rtl/breakpoint_watchpoint_unit.sv
hw/rtl/bwu_checker.sv
sim/tb_top.sv
